/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/i2cs_pkg.sv */
// ----------------------------------------------------------------------------
// i2cs_pkg
// Shared constants and codes of the I2C transaction sequencer.
// ----------------------------------------------------------------------------
package i2cs_pkg;

	localparam int TX_DEPTH = 16;
	localparam int RX_MAX   = 16;
	localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

	localparam int OP_W    = 3;
	localparam int ADDR_W  = 7;
	localparam int LEN_W   = 5;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 4;
	localparam int ACT_W   = 3;
	localparam int STAT_W  = 3;

	localparam logic [OP_W-1:0] OP_START   = 3'd0;
	localparam logic [OP_W-1:0] OP_TX_RDY  = 3'd1;
	localparam logic [OP_W-1:0] OP_RX_BYTE = 3'd2;
	localparam logic [OP_W-1:0] OP_NACK    = 3'd3;
	localparam logic [OP_W-1:0] OP_LOAD    = 3'd4;

	localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SEND       = 3'd1;
	localparam logic [ACT_W-1:0] ACT_START_WR   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_START_RD   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RESTART_RD = 3'd4;

endpackage

/* rtl/i2cs_cmd_if.sv */
// ----------------------------------------------------------------------------
// i2cs_cmd_if
// Command channel of the I2C transaction sequencer.
// ----------------------------------------------------------------------------
interface i2cs_cmd_if;
	import i2cs_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [ADDR_W-1:0] target_address;
	logic [LEN_W-1:0]  write_length;
	logic [LEN_W-1:0]  read_length;
	logic [BYTE_W-1:0] data_byte;
	logic [IDX_W-1:0]  load_index;

	modport source (
		output valid, opcode, target_address, write_length, read_length,
		       data_byte, load_index,
		input  ready
	);

	modport sink (
		input  valid, opcode, target_address, write_length, read_length,
		       data_byte, load_index,
		output ready
	);
endinterface

/* rtl/i2cs_rsp_if.sv */
// ----------------------------------------------------------------------------
// i2cs_rsp_if
// Response channel of the I2C transaction sequencer.
// ----------------------------------------------------------------------------
interface i2cs_rsp_if;
	import i2cs_pkg::*;

	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  bus_action;
	logic              stop_now;
	logic [ADDR_W-1:0] address_out;
	logic [BYTE_W-1:0] tx_byte;
	logic [BYTE_W-1:0] rx_byte;
	logic [IDX_W-1:0]  rx_index;
	logic              rx_valid;
	logic [STAT_W-1:0] status;
	logic [LEN_W-1:0]  sent_count;
	logic [LEN_W-1:0]  received_count;

	modport source (
		output valid, bus_action, stop_now, address_out, tx_byte, rx_byte,
		       rx_index, rx_valid, status, sent_count, received_count,
		input  ready
	);

	modport sink (
		input  valid, bus_action, stop_now, address_out, tx_byte, rx_byte,
		       rx_index, rx_valid, status, sent_count, received_count,
		output ready
	);
endinterface

/* rtl/i2cs_ram.sv */
// ----------------------------------------------------------------------------
// i2cs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module i2cs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/i2c_master_transaction_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_unit
// Master-side sequencer for one I2C write-then-read transaction.
//
// The host sends command words on cmd: start (address and lengths), transmit
// ready, received byte, NACK and transmit buffer load. For every command word
// exactly one response word leaves on rsp, in order: the next bus action, a
// stop request, the received byte with its index, status and byte counts.
// Transmit bytes live in a 16-entry RAM loaded by the load command and read
// through its registered port when a send is due.
// Throughput: one command word per cycle while rsp does not stall; the RAM
// read stage and the output register form a two-deep pipeline.
// Reset clears the phase to idle and zeroes the address and counters; the
// transmit RAM is not cleared and holds garbage until loaded.
// When rsp stalls, the output register holds, then the read stage fills and
// cmd.ready drops; no word is lost or repeated.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_unit (
	input  logic clk,
	input  logic arst_n,
	i2cs_cmd_if.sink   cmd,
	i2cs_rsp_if.source rsp
);
	import i2cs_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [STAT_W-1:0] {
		PH_IDLE = 3'd0,
		PH_TX   = 3'd1,
		PH_RX   = 3'd2,
		PH_DONE = 3'd3,
		PH_NAK  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic              stop;
		logic [ADDR_W-1:0] addr;
		logic              send;
		logic [BYTE_W-1:0] rxb;
		logic [IDX_W-1:0]  rxi;
		logic              rxv;
		logic [STAT_W-1:0] status;
		logic [LEN_W-1:0]  sent;
		logic [LEN_W-1:0]  recv;
	} resp_t;

	localparam logic [LEN_W-1:0] TX_MAX_L = LEN_W'(TX_DEPTH);
	localparam logic [LEN_W-1:0] RX_MAX_L = LEN_W'(RX_MAX);

	phase_t            phase_q, phase_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [LEN_W-1:0]  wtot_q, wtot_d, rtot_q, rtot_d;
	logic [LEN_W-1:0]  wdone_q, wdone_d, rdone_q, rdone_d;
	logic [LEN_W-1:0]  rleft;

	logic  s1_valid_s1, out_valid_q;
	resp_t res_d, res_s1;
	logic  accept, s1_move;
	logic  ram_we, ram_re;
	logic [BYTE_W-1:0] ram_rdata;

	assign s1_move    = s1_valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready  = !s1_valid_s1 || s1_move;
	assign accept     = cmd.valid && cmd.ready;
	assign rleft      = rtot_q - rdone_q;

	assign ram_we = accept && (cmd.opcode == OP_LOAD) &&
	                (32'(cmd.load_index) < TX_DEPTH);
	assign ram_re = accept && res_d.send;

	i2cs_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(TX_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(TX_AW'(cmd.load_index)),
		.wdata(cmd.data_byte),
		.re   (ram_re),
		.raddr(TX_AW'(wdone_q)),
		.rdata(ram_rdata)
	);

	always_comb begin
		phase_d = phase_q;
		addr_d  = addr_q;
		wtot_d  = wtot_q;
		rtot_d  = rtot_q;
		wdone_d = wdone_q;
		rdone_d = rdone_q;
		res_d   = '0;
		case (cmd.opcode)
			OP_START: begin
				addr_d  = cmd.target_address;
				wtot_d  = (cmd.write_length > TX_MAX_L) ? TX_MAX_L : cmd.write_length;
				rtot_d  = (cmd.read_length > RX_MAX_L) ? RX_MAX_L : cmd.read_length;
				wdone_d = '0;
				rdone_d = '0;
				if (wtot_d != '0) begin
					res_d.act = ACT_START_WR;
					phase_d   = PH_TX;
				end else if (rtot_d != '0) begin
					res_d.act  = ACT_START_RD;
					phase_d    = PH_RX;
					res_d.stop = (rtot_d == LEN_W'(1));
				end else begin
					res_d.act  = ACT_START_WR;
					res_d.stop = 1'b1;
					phase_d    = PH_DONE;
				end
			end
			OP_TX_RDY: begin
				if (phase_q == PH_TX) begin
					if (wdone_q < wtot_q) begin
						res_d.act  = ACT_SEND;
						res_d.send = 1'b1;
						wdone_d    = wdone_q + LEN_W'(1);
					end else if (rtot_q != '0) begin
						res_d.act  = ACT_RESTART_RD;
						phase_d    = PH_RX;
						res_d.stop = (rtot_q == LEN_W'(1));
					end else begin
						res_d.stop = 1'b1;
						phase_d    = PH_DONE;
					end
				end
			end
			OP_RX_BYTE: begin
				if (phase_q == PH_RX && rdone_q < rtot_q) begin
					res_d.rxb  = cmd.data_byte;
					res_d.rxi  = rdone_q[IDX_W-1:0];
					res_d.rxv  = 1'b1;
					rdone_d    = rdone_q + LEN_W'(1);
					res_d.stop = (rleft == LEN_W'(2));
					if (rleft == LEN_W'(1)) begin
						phase_d = PH_DONE;
					end
				end
			end
			OP_NACK: begin
				if (phase_q == PH_TX || phase_q == PH_RX) begin
					phase_d = PH_NAK;
				end
			end
			default: ;
		endcase
		res_d.addr   = addr_d;
		res_d.status = STAT_W'(phase_d);
		res_d.sent   = wdone_d;
		res_d.recv   = rdone_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q  <= '0;
			wtot_q  <= '0;
			rtot_q  <= '0;
			wdone_q <= '0;
			rdone_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			wtot_q  <= wtot_d;
			rtot_q  <= rtot_d;
			wdone_q <= wdone_d;
			rdone_q <= rdone_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ready) begin
				s1_valid_s1 <= cmd.valid;
			end
			if (!out_valid_q || rsp.ready) begin
				out_valid_q <= s1_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
		if (s1_move) begin
			rsp.bus_action     <= res_s1.act;
			rsp.stop_now       <= res_s1.stop;
			rsp.address_out    <= res_s1.addr;
			rsp.tx_byte        <= res_s1.send ? ram_rdata : '0;
			rsp.rx_byte        <= res_s1.rxb;
			rsp.rx_index       <= res_s1.rxi;
			rsp.rx_valid       <= res_s1.rxv;
			rsp.status         <= res_s1.status;
			rsp.sent_count     <= res_s1.sent;
			rsp.received_count <= res_s1.recv;
		end
	end

	assign rsp.valid = out_valid_q;

	`ASSERT_CLK(a_wdone_bound, clk, arst_n, wdone_q <= wtot_q, "sent count above write total")
	`ASSERT_CLK(a_rdone_bound, clk, arst_n, rdone_q <= rtot_q, "received count above read total")
	`ASSERT_CLK(a_rx_has_len, clk, arst_n, (phase_q == PH_RX) |-> (rtot_q != '0), "receive phase with empty read")
	`ASSERT_CLK(a_s1_hold, clk, arst_n, (s1_valid_s1 && !s1_move) |=> s1_valid_s1, "read stage dropped a stalled word")
	`ASSERT_CLK(a_rx_status, clk, arst_n, (rsp.valid && rsp.rx_valid) |-> (rsp.status == STAT_W'(PH_RX) || rsp.status == STAT_W'(PH_DONE)), "rx byte with bad status")

endmodule

/* tb/i2cs_xfer_checker.sv */
// ----------------------------------------------------------------------------
// i2cs_xfer_checker
// Watches the command and response channels of the I2C transaction
// sequencer, predicts every response word from the accepted command words
// and compares the two field by field, in order.
// ----------------------------------------------------------------------------
module i2cs_xfer_checker (
	input  logic clk,
	input  logic arst_n,
	i2cs_cmd_if  cmd,
	i2cs_rsp_if  rsp,
	output int   pending,
	output int   mismatches
);
	import i2cs_pkg::*;

	typedef enum logic [STAT_W-1:0] {
		ST_IDLE = 3'd0,
		ST_TX   = 3'd1,
		ST_RX   = 3'd2,
		ST_DONE = 3'd3,
		ST_NAK  = 3'd4
	} xfer_state_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic              stop;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] txb;
		logic [BYTE_W-1:0] rxb;
		logic [IDX_W-1:0]  rxi;
		logic              rxv;
		logic [STAT_W-1:0] status;
		logic [LEN_W-1:0]  sent;
		logic [LEN_W-1:0]  rcvd;
	} bus_step_t;

	xfer_state_t       state;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  wr_total;
	logic [LEN_W-1:0]  rd_total;
	logic [LEN_W-1:0]  wr_done;
	logic [LEN_W-1:0]  rd_done;
	logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
	bus_step_t         due_steps [$];
	bus_step_t         got;
	bus_step_t         want;
	int                bad_words;

	function automatic bus_step_t step_sequencer(
		input logic [OP_W-1:0]   op,
		input logic [ADDR_W-1:0] ta,
		input logic [LEN_W-1:0]  wl,
		input logic [LEN_W-1:0]  rl,
		input logic [BYTE_W-1:0] db,
		input logic [IDX_W-1:0]  li
	);
		bus_step_t        s;
		logic [LEN_W-1:0] left;
		s = '0;
		case (op)
		OP_START: begin
			addr_q   = ta;
			wr_total = (wl > TX_DEPTH) ? LEN_W'(TX_DEPTH) : wl;
			rd_total = (rl > RX_MAX) ? LEN_W'(RX_MAX) : rl;
			wr_done  = '0;
			rd_done  = '0;
			if (wr_total != 0) begin
				s.action = ACT_START_WR;
				state    = ST_TX;
			end else if (rd_total != 0) begin
				s.action = ACT_START_RD;
				state    = ST_RX;
				s.stop   = (rd_total == 1);
			end else begin
				s.action = ACT_START_WR;
				s.stop   = 1'b1;
				state    = ST_DONE;
			end
		end
		OP_TX_RDY: begin
			if (state == ST_TX) begin
				if (wr_done < wr_total) begin
					s.action = ACT_SEND;
					s.txb    = tx_mem[wr_done[TX_AW-1:0]];
					wr_done  = wr_done + 1'b1;
				end else if (rd_total != 0) begin
					s.action = ACT_RESTART_RD;
					state    = ST_RX;
					s.stop   = (rd_total == 1);
				end else begin
					s.stop = 1'b1;
					state  = ST_DONE;
				end
			end
		end
		OP_RX_BYTE: begin
			if (state == ST_RX && rd_done < rd_total) begin
				left    = rd_total - rd_done;
				s.rxb   = db;
				s.rxi   = rd_done[IDX_W-1:0];
				s.rxv   = 1'b1;
				rd_done = rd_done + 1'b1;
				if (left == 2)
					s.stop = 1'b1;
				else if (left == 1)
					state = ST_DONE;
			end
		end
		OP_NACK: begin
			if (state == ST_TX || state == ST_RX)
				state = ST_NAK;
		end
		OP_LOAD: begin
			if (int'(li) < TX_DEPTH)
				tx_mem[li] = db;
		end
		default: ;
		endcase
		s.addr   = addr_q;
		s.status = state;
		s.sent   = wr_done;
		s.rcvd   = rd_done;
		return s;
	endfunction

	function automatic string show_step(input bus_step_t s);
		return {$sformatf("act=%0d stop=%0d addr=%h tx=%h rx=%h idx=%0d rxv=%0d st=%0d",
			s.action, s.stop, s.addr, s.txb, s.rxb, s.rxi, s.rxv, s.status),
			$sformatf(" sent=%0d rcvd=%0d", s.sent, s.rcvd)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state      = ST_IDLE;
			addr_q     = '0;
			wr_total   = '0;
			rd_total   = '0;
			wr_done    = '0;
			rd_done    = '0;
			bad_words  = 0;
			due_steps.delete();
			pending    <= 0;
			mismatches <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = {rsp.bus_action, rsp.stop_now, rsp.address_out, rsp.tx_byte,
					rsp.rx_byte, rsp.rx_index, rsp.rx_valid, rsp.status,
					rsp.sent_count, rsp.received_count};
				if (due_steps.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("unexpected response word: %s", show_step(got));
				end else begin
					want = due_steps.pop_front();
					if (got.action !== want.action || got.stop !== want.stop ||
					    got.addr !== want.addr || got.txb !== want.txb ||
					    got.rxb !== want.rxb || got.rxi !== want.rxi ||
					    got.rxv !== want.rxv || got.status !== want.status ||
					    got.sent !== want.sent || got.rcvd !== want.rcvd) begin
						bad_words++;
						if (bad_words <= 10) begin
							$display("response mismatch");
							$display("  expected %s", show_step(want));
							$display("  actual   %s", show_step(got));
						end
					end
				end
			end
			if (cmd.valid && cmd.ready)
				due_steps.push_back(step_sequencer(cmd.opcode, cmd.target_address,
					cmd.write_length, cmd.read_length, cmd.data_byte, cmd.load_index));
			pending    <= due_steps.size();
			mismatches <= bad_words;
		end
	end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the I2C transaction sequencer: a short directed run over the
// corner cases, then random write-then-read transactions mixed with stray
// and broken command words, under three patterns of channel stalls.
// ----------------------------------------------------------------------------
module tb;
	import i2cs_pkg::*;

	localparam int RAND_WORDS   = 500;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  wlen;
		logic [LEN_W-1:0]  rlen;
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0]  idx;
	} cmd_word_t;

	logic              clk;
	logic              arst_n;
	int                pending;
	int                mismatches;
	int                cycles = 0;
	int                src_idle;
	int                snk_idle;
	int                useful;
	int                mode;
	bit [TX_DEPTH-1:0] loaded;

	i2cs_cmd_if cmd_ch ();
	i2cs_rsp_if rsp_ch ();

	i2c_master_transaction_sequencer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	i2cs_xfer_checker xfer_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.pending    (pending),
		.mismatches (mismatches)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles       <= cycles + 1;
		rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic cmd_word_t rand_word(input logic [OP_W-1:0] op);
		cmd_word_t w;
		w.op   = op;
		w.addr = ADDR_W'($urandom_range(127));
		w.wlen = LEN_W'($urandom_range(31));
		w.rlen = LEN_W'($urandom_range(31));
		w.data = BYTE_W'($urandom_range(255));
		w.idx  = IDX_W'($urandom_range(15));
		return w;
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 0;
		if (r < 70)
			return $urandom_range(4, 1);
		if (r < 90)
			return $urandom_range(16, 5);
		return $urandom_range(31, 17);
	endfunction

	task automatic put_word(input cmd_word_t w);
		while ($urandom_range(99) < src_idle) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid          <= 1'b1;
		cmd_ch.opcode         <= w.op;
		cmd_ch.target_address <= w.addr;
		cmd_ch.write_length   <= w.wlen;
		cmd_ch.read_length    <= w.rlen;
		cmd_ch.data_byte      <= w.data;
		cmd_ch.load_index     <= w.idx;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic put_op(input logic [OP_W-1:0] op);
		put_word(rand_word(op));
	endtask

	task automatic put_load(input int slot, input int value);
		cmd_word_t w;
		w      = rand_word(OP_LOAD);
		w.idx  = IDX_W'(slot);
		w.data = BYTE_W'(value);
		loaded[slot] = 1'b1;
		put_word(w);
	endtask

	task automatic put_rx(input int value);
		cmd_word_t w;
		w      = rand_word(OP_RX_BYTE);
		w.data = BYTE_W'(value);
		put_word(w);
	endtask

	// load every slot the transfer can reach before it starts
	task automatic put_start(input int addr, input int wl, input int rl);
		cmd_word_t w;
		for (int k = 0; k < wl && k < TX_DEPTH; k++)
			if (!loaded[k])
				put_load(k, $urandom_range(255));
		w      = rand_word(OP_START);
		w.addr = ADDR_W'(addr);
		w.wlen = LEN_W'(wl);
		w.rlen = LEN_W'(rl);
		put_word(w);
	endtask

	task automatic put_stray();
		int r;
		r = $urandom_range(3);
		case (r)
		0: put_op(OP_TX_RDY);
		1: put_op(OP_RX_BYTE);
		2: put_load($urandom_range(TX_DEPTH - 1), $urandom_range(255));
		default: put_op(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)));
		endcase
	endtask

	task automatic put_noise();
		logic [OP_W-1:0] op;
		op = OP_W'($urandom_range(OP_SPARE_LAST));
		if (op == OP_START)
			put_start($urandom_range(127), $urandom_range(31), $urandom_range(31));
		else if (op == OP_LOAD)
			put_load($urandom_range(TX_DEPTH - 1), $urandom_range(255));
		else
			put_op(op);
	endtask

	task automatic disrupt(output bit cut);
		int r;
		r   = $urandom_range(99);
		cut = 1'b0;
		if (r < 3) begin
			put_op(OP_NACK);
			cut = 1'b1;
		end else if (r < 5) begin
			cut = 1'b1;
		end else if (r < 10) begin
			put_stray();
		end
	endtask

	task automatic run_xfer();
		int wl;
		int rl;
		int n_tx;
		int n_rx;
		bit cut;
		wl   = pick_len();
		rl   = pick_len();
		n_tx = (wl == 0) ? 0 : ((wl > TX_DEPTH) ? TX_DEPTH : wl) + 1;
		n_rx = (rl > RX_MAX) ? RX_MAX : rl;
		if ($urandom_range(4) == 0)
			put_load($urandom_range(TX_DEPTH - 1), $urandom_range(255));
		put_start($urandom_range(127), wl, rl);
		useful++;
		cut = 1'b0;
		for (int i = 0; i < n_tx && !cut; i++) begin
			disrupt(cut);
			if (!cut) begin
				put_op(OP_TX_RDY);
				useful++;
			end
		end
		for (int i = 0; i < n_rx && !cut; i++) begin
			disrupt(cut);
			if (!cut) begin
				put_rx($urandom_range(255));
				useful++;
			end
		end
		if (!cut && $urandom_range(4) == 0)
			put_stray();
	endtask

	// hold the sender until every response word is back
	task automatic drain_responses();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		arst_n                 = 1'b0;
		src_idle               = 17;
		snk_idle               = 68;
		loaded                 = '0;
		mode                   = 0;
		useful                 = 0;
		cmd_ch.valid          <= 1'b0;
		cmd_ch.opcode         <= OP_START;
		cmd_ch.target_address <= '0;
		cmd_ch.write_length   <= '0;
		cmd_ch.read_length    <= '0;
		cmd_ch.data_byte      <= '0;
		cmd_ch.load_index     <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_load(0, 8'h00);
		put_load(1, 8'hFF);
		put_load(TX_DEPTH - 1, 8'hA5);
		put_start(7'h7F, 1, 2);
		put_op(OP_TX_RDY);
		put_op(OP_TX_RDY);
		put_rx(8'hFF);
		put_rx(8'h00);
		put_rx(8'h3C);
		put_op(OP_TX_RDY);
		put_op(OP_NACK);
		put_start(7'h00, 0, 1);
		put_rx(8'h5A);
		put_start(7'h2A, 0, 0);
		put_start(7'h55, 2, 0);
		put_op(OP_TX_RDY);
		put_start(7'h01, 0, 3);
		put_rx(8'h81);
		put_op(OP_NACK);
		put_rx(8'h7E);
		put_start(7'h40, 2, 0);
		put_op(OP_TX_RDY);
		put_op(OP_TX_RDY);
		put_op(OP_TX_RDY);
		put_op(OP_SPARE_FIRST);
		put_op(OP_SPARE_LAST);

		while (useful < RAND_WORDS) begin
			if (mode == 0 && useful >= RAND_WORDS / 3) begin
				drain_responses();
				src_idle = 68;
				snk_idle = 17;
				mode     = 1;
			end else if (mode == 1 && useful >= 2 * RAND_WORDS / 3) begin
				drain_responses();
				src_idle = 0;
				snk_idle = 0;
				mode     = 2;
			end
			if ($urandom_range(99) < 80)
				run_xfer();
			else
				put_noise();
		end

		drain_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/i2cs_pkg.sv
rtl/i2cs_cmd_if.sv
rtl/i2cs_rsp_if.sv
rtl/i2cs_ram.sv
rtl/i2c_master_transaction_sequencer_unit.sv
tb/i2cs_xfer_checker.sv
tb/tb.sv
